// File: sv/assert_macros.svh
// assertion macros used by the rtl top file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/lbcg_pkg.sv
// types, constants and arithmetic helpers of the luma band colour grade
`default_nettype none
package lbcg_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TONE  = 4'd0,
    REG_RED   = 4'd1,
    REG_GREEN = 4'd2,
    REG_BLUE  = 4'd3,
    REG_POP   = 4'd4,
    REG_SAT   = 4'd5,
    REG_CON   = 4'd6,
    REG_BRI   = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } pix_out_t;

  typedef logic signed [25:0] ch_t;
  typedef logic [16:0] wgt_t;

  typedef struct packed {
    wgt_t wl;
    wgt_t wlm;
    wgt_t whm;
    wgt_t wh;
    wgt_t wm;
  } band_wgt_t;

  typedef struct packed {
    logic [63:0]        tone;
    logic [47:0]        red;
    logic [47:0]        green;
    logic [47:0]        blue;
    logic signed [29:0] pop_k;
    logic signed [15:0] sat;
    logic signed [15:0] con;
    logic signed [23:0] bri_k;
  } grade_cfg_t;

  localparam logic [16:0] ONE16    = 17'd65536;
  localparam ch_t         MID_GREY = 26'sd1044480;
  localparam ch_t         CH_MAX   = 26'sd33554431;
  localparam ch_t         CH_MIN   = {1'b1, 25'd0};
  localparam logic [20:0] Y_MAX    = 21'd2088960;
  localparam logic [48:0] RECIP255 = 49'd16843010;

  // exact floor(n / 255) for n below 2^24
  function automatic wgt_t div255(input logic [23:0] n);
    logic [48:0] p;
    p = {25'd0, n} * RECIP255;
    return p[48:32];
  endfunction

  function automatic ch_t sat_ch(input logic signed [33:0] x);
    ch_t r;
    if (x > 34'(CH_MAX)) begin
      r = CH_MAX;
    end else if (x < 34'(CH_MIN)) begin
      r = CH_MIN;
    end else begin
      r = $signed(x[25:0]);
    end
    return r;
  endfunction

  // rec.709 luma of working channels, rounded from 16 fraction bits
  function automatic logic signed [27:0] luma13(input ch_t r, input ch_t g, input ch_t b);
    logic signed [45:0] s;
    s = 46'(r) * 46'sd13933 + 46'(g) * 46'sd46871 + 46'(b) * 46'sd4732 + 46'sd32768;
    return 28'(s >>> 16);
  endfunction

  function automatic logic signed [33:0] mul_gw(input logic signed [15:0] g, input wgt_t w);
    return 34'(g) * $signed({17'd0, w});
  endfunction

endpackage
`default_nettype wire

// File: sv/lbcg_weight.sv
// input luma and band weights, four stages
`default_nettype none
module lbcg_weight (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  lbcg_pkg::pix_in_t   in_pix,
  output logic                out_valid,
  output lbcg_pkg::pix_in_t   out_pix,
  output lbcg_pkg::band_wgt_t out_wgt
);
  import lbcg_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r;
  pix_in_t p1_r, p2_r, p3_r, p4_r;
  logic [23:0] num_r, num_nxt;
  wgt_t lum_r, lum_nxt;
  wgt_t wl_r, wl_nxt, wh_r, wh_nxt;
  logic [17:0] omt_r, omt_nxt;
  band_wgt_t wgt_r, wgt_nxt;

  logic [16:0] inv;
  logic [34:0] sq_l, sq_h;
  logic signed [19:0] tq, tc;
  logic signed [18:0] wm_s;
  wgt_t wm, wlm;
  logic [35:0] pm;

  always_comb begin
    num_nxt = 24'd13933 * 24'(in_pix.red_in) + 24'd46871 * 24'(in_pix.green_in)
            + 24'd4732 * 24'(in_pix.blue_in) + 24'd127;
    lum_nxt = div255(num_r);
  end

  always_comb begin
    inv    = ONE16 - lum_r;
    sq_l   = 35'(inv) * 35'(inv) + 35'd32768;
    sq_h   = 35'(lum_r) * 35'(lum_r) + 35'd32768;
    wl_nxt = sq_l[32:16];
    wh_nxt = sq_h[32:16];
    tq     = 20'(($signed({3'b000, lum_r}) - 20'sd32768) * 20'sd4);
    if (tq > 20'sd65536) begin
      tc = 20'sd65536;
    end else if (tq < -20'sd65536) begin
      tc = -20'sd65536;
    end else begin
      tc = tq;
    end
    omt_nxt = 18'(20'sd65536 - tc);
  end

  always_comb begin
    wm_s = 19'sd65536 - $signed({2'b00, wl_r}) - $signed({2'b00, wh_r});
    wm   = (wm_s < 0) ? 17'd0 : wm_s[16:0];
    pm   = 36'(wm) * 36'(omt_r) + 36'd65536;
    wlm  = pm[33:17];
    wgt_nxt.wl  = wl_r;
    wgt_nxt.wlm = wlm;
    wgt_nxt.whm = wm - wlm;
    wgt_nxt.wh  = wh_r;
    wgt_nxt.wm  = wm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= in_pix;
      num_r <= num_nxt;
      p2_r  <= p1_r;
      lum_r <= lum_nxt;
      p3_r  <= p2_r;
      wl_r  <= wl_nxt;
      wh_r  <= wh_nxt;
      omt_r <= omt_nxt;
      p4_r  <= p3_r;
      wgt_r <= wgt_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_pix   = p4_r;
  assign out_wgt   = wgt_r;

endmodule
`default_nettype wire

// File: sv/lbcg_offset.sv
// band and channel offsets, three stages
`default_nettype none
module lbcg_offset (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  lbcg_pkg::pix_in_t    in_pix,
  input  lbcg_pkg::band_wgt_t  in_wgt,
  input  lbcg_pkg::grade_cfg_t cfg,
  output logic                 out_valid,
  output logic [2:0][25:0]     out_x
);
  import lbcg_pkg::*;

  logic v1_r, v2_r, v3_r;
  pix_in_t p1_r, p2_r;
  logic signed [33:0] tp_r [4];
  logic signed [33:0] tp_nxt [4];
  logic signed [33:0] cp_r [3][3];
  logic signed [33:0] cp_nxt [3][3];
  logic signed [37:0] s_r [3];
  logic signed [37:0] s_nxt [3];
  logic [2:0][25:0] x_r, x_nxt;
  logic [2:0][47:0] chan;
  logic [2:0][7:0] code;
  logic signed [45:0] m;
  logic signed [33:0] v;

  always_comb begin
    chan = {cfg.red, cfg.green, cfg.blue};
    tp_nxt[0] = mul_gw($signed(cfg.tone[15:0]), in_wgt.wl);
    tp_nxt[1] = mul_gw($signed(cfg.tone[31:16]), in_wgt.wlm);
    tp_nxt[2] = mul_gw($signed(cfg.tone[47:32]), in_wgt.whm);
    tp_nxt[3] = mul_gw($signed(cfg.tone[63:48]), in_wgt.wh);
    for (int i = 0; i < 3; i++) begin
      cp_nxt[i][0] = mul_gw($signed(chan[2-i][15:0]), in_wgt.wl);
      cp_nxt[i][1] = mul_gw($signed(chan[2-i][31:16]), in_wgt.wm);
      cp_nxt[i][2] = mul_gw($signed(chan[2-i][47:32]), in_wgt.wh);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_nxt[i] = 38'(tp_r[0]) + 38'(tp_r[1]) + 38'(tp_r[2]) + 38'(tp_r[3])
               + 38'(cp_r[i][0]) + 38'(cp_r[i][1]) + 38'(cp_r[i][2]);
    end
  end

  always_comb begin
    code = {p2_r.blue_in, p2_r.green_in, p2_r.red_in};
    x_nxt = '0;
    m = '0;
    v = '0;
    for (int i = 0; i < 3; i++) begin
      m = (46'(s_r[i]) <<< 8) - 46'(s_r[i]) + 46'sd32768;
      v = 34'(m >>> 16) + $signed({13'd0, code[i], 13'd0});
      x_nxt[i] = sat_ch(v);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= in_pix;
      p2_r <= p1_r;
      tp_r <= tp_nxt;
      cp_r <= cp_nxt;
      s_r  <= s_nxt;
      x_r  <= x_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_x     = x_r;

endmodule
`default_nettype wire

// File: sv/lbcg_pop.sv
// mid-tone pop contrast, five stages
`default_nettype none
module lbcg_pop (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][25:0]     in_x,
  input  lbcg_pkg::grade_cfg_t cfg,
  output logic                 out_valid,
  output logic [2:0][25:0]     out_x
);
  import lbcg_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [2:0][25:0] x1_r, x2_r, x3_r, x4_r, x5_r, x5_nxt;
  logic [20:0] yc_r, yc_nxt;
  wgt_t n2_r, n2_nxt;
  logic signed [17:0] f_r, f_nxt;
  logic signed [44:0] pp_r [3];
  logic signed [44:0] pp_nxt [3];

  logic signed [27:0] yl;
  logic signed [18:0] d, ad;
  wgt_t midw;
  logic signed [47:0] fp;

  always_comb begin
    yl = luma13($signed(in_x[0]), $signed(in_x[1]), $signed(in_x[2]));
    if (yl < 0) begin
      yc_nxt = '0;
    end else if (yl > $signed({7'd0, Y_MAX})) begin
      yc_nxt = Y_MAX;
    end else begin
      yc_nxt = yl[20:0];
    end
    n2_nxt = div255({yc_r, 3'b000} + 24'd127);
  end

  always_comb begin
    d     = $signed({1'b0, n2_r, 1'b0}) - 19'sd65536;
    ad    = (d < 0) ? -d : d;
    midw  = 17'(19'sd65536 - ad);
    fp    = 48'(cfg.pop_k) * $signed({31'd0, midw});
    f_nxt = 18'((fp + 48'sd268435456) >>> 29);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pp_nxt[i] = 45'(f_r) * 45'(27'($signed(x3_r[i])) - 27'(MID_GREY));
      x5_nxt[i] = sat_ch(34'($signed(x4_r[i])) + 34'((pp_r[i] + 45'sd32768) >>> 16));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= in_x;
      yc_r <= yc_nxt;
      x2_r <= x1_r;
      n2_r <= n2_nxt;
      x3_r <= x2_r;
      f_r  <= f_nxt;
      x4_r <= x3_r;
      pp_r <= pp_nxt;
      x5_r <= x5_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_x     = x5_r;

endmodule
`default_nettype wire

// File: sv/lbcg_grade.sv
// saturation, contrast, brightness and output rounding, five stages
`default_nettype none
module lbcg_grade (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][25:0]     in_x,
  input  lbcg_pkg::grade_cfg_t cfg,
  output logic                 out_valid,
  output lbcg_pkg::pix_out_t   out_pix
);
  import lbcg_pkg::*;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [2:0][25:0] x1_r, x3_r, x3_nxt;
  logic signed [27:0] y1_r, y1_nxt, y2_r;
  logic signed [44:0] dp_r [3];
  logic signed [44:0] dp_nxt [3];
  logic signed [42:0] cp_r [3];
  logic signed [42:0] cp_nxt [3];
  logic [2:0][7:0] o_nxt;
  pix_out_t pix_r;

  ch_t v1, v2;
  logic [20:0] vc;
  logic [21:0] vr;

  always_comb begin
    y1_nxt = luma13($signed(in_x[0]), $signed(in_x[1]), $signed(in_x[2]));
    for (int i = 0; i < 3; i++) begin
      dp_nxt[i] = 45'(29'($signed(x1_r[i])) - 29'(y1_r)) * 45'(cfg.sat);
      x3_nxt[i] = sat_ch(34'(y2_r) + 34'((dp_r[i] + 45'sd4096) >>> 13));
      cp_nxt[i] = 43'(27'($signed(x3_r[i])) - 27'(MID_GREY)) * 43'(cfg.con);
    end
  end

  always_comb begin
    o_nxt = '0;
    v1 = '0;
    v2 = '0;
    vc = '0;
    vr = '0;
    for (int i = 0; i < 3; i++) begin
      v1 = sat_ch(34'(MID_GREY) + 34'((cp_r[i] + 43'sd4096) >>> 13));
      v2 = sat_ch(34'(v1) + 34'(cfg.bri_k));
      if (v2 < 0) begin
        vc = '0;
      end else if (v2 > $signed({5'd0, Y_MAX})) begin
        vc = Y_MAX;
      end else begin
        vc = v2[20:0];
      end
      vr = {1'b0, vc} + 22'd4096;
      o_nxt[i] = vr[20:13];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= in_x;
      y1_r  <= y1_nxt;
      dp_r  <= dp_nxt;
      y2_r  <= y1_r;
      x3_r  <= x3_nxt;
      cp_r  <= cp_nxt;
      pix_r <= '{red_out: o_nxt[0], green_out: o_nxt[1], blue_out: o_nxt[2]};
    end
  end

  assign out_valid = v5_r;
  assign out_pix   = pix_r;

endmodule
`default_nettype wire

// File: sv/luma_band_colour_grade_top.sv
// luma band colour grade: one rgb word in, one graded rgb word out
//
// input channel in_valid/in_ready/in_data carries one 8-bit rgb pixel a word,
// output channel out_valid/out_ready/out_data returns the graded pixel.
// registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data,
// cfg_ready is always high; indexes above the last register are ignored.
// write registers only while no pixel is in flight.
// from input accept to output valid a pixel passes the weight (4),
// offset (3), pop (5) and grade (5) stages. throughput is one pixel per
// cycle while the receiver does not stall; the last grade stage is the output
// register, so a new word is taken in the same cycle a result is taken.
// when the receiver stalls the whole pipeline holds, bubbles included,
// and in_ready drops; nothing is lost or repeated.
// reset clears all valid bits and returns the registers to their defaults:
// unity saturation and contrast, all offsets and pop zero.
`default_nettype none
`include "assert_macros.svh"
module luma_band_colour_grade_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lbcg_pkg::pix_in_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lbcg_pkg::pix_out_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbcg_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [lbcg_pkg::CfgDataW-1:0]     cfg_data
);
  import lbcg_pkg::*;

  logic [63:0] tone_r;
  logic [47:0] red_r, green_r, blue_r;
  logic signed [15:0] pop_r, sat_r, con_r, bri_r;
  logic signed [29:0] pop_k_r;
  logic signed [23:0] bri_k_r;
  grade_cfg_t cfg;

  logic en;
  logic w_valid, o_valid, p_valid;
  pix_in_t w_pix;
  band_wgt_t w_wgt;
  logic [2:0][25:0] o_x, p_x;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r  <= '0;
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
      pop_r   <= '0;
      sat_r   <= 16'sd8192;
      con_r   <= 16'sd8192;
      bri_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_TONE:  tone_r  <= cfg_data;
        REG_RED:   red_r   <= cfg_data[47:0];
        REG_GREEN: green_r <= cfg_data[47:0];
        REG_BLUE:  blue_r  <= cfg_data[47:0];
        REG_POP:   pop_r   <= $signed(cfg_data[15:0]);
        REG_SAT:   sat_r   <= $signed(cfg_data[15:0]);
        REG_CON:   con_r   <= $signed(cfg_data[15:0]);
        REG_BRI:   bri_r   <= $signed(cfg_data[15:0]);
        default: begin
        end
      endcase
    end
  end

  // scaled copies, settled long before a pixel reaches their stage
  always_ff @(posedge clk) begin
    pop_k_r <= 30'(pop_r) * 30'sd13107;
    bri_k_r <= 24'(bri_r) * 24'sd255;
  end

  always_comb begin
    cfg.tone  = tone_r;
    cfg.red   = red_r;
    cfg.green = green_r;
    cfg.blue  = blue_r;
    cfg.pop_k = pop_k_r;
    cfg.sat   = sat_r;
    cfg.con   = con_r;
    cfg.bri_k = bri_k_r;
  end

  lbcg_weight u_weight (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid && in_ready),
    .in_pix    (in_data),
    .out_valid (w_valid),
    .out_pix   (w_pix),
    .out_wgt   (w_wgt)
  );

  lbcg_offset u_offset (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (w_valid),
    .in_pix    (w_pix),
    .in_wgt    (w_wgt),
    .cfg       (cfg),
    .out_valid (o_valid),
    .out_x     (o_x)
  );

  lbcg_pop u_pop (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (o_valid),
    .in_x      (o_x),
    .cfg       (cfg),
    .out_valid (p_valid),
    .out_x     (p_x)
  );

  lbcg_grade u_grade (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_valid),
    .in_x      (p_x),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_pix   (out_data)
  );

  `ASSERT_CLK(a_out_idle_after_reset, $past(!rst_n) |-> !out_valid, "output valid right after reset")
  `ASSERT_CLK(a_backpressure_source, !in_ready |-> (out_valid && !out_ready), "input stalled without output stall")
  `ASSERT_CLK(a_stall_reaches_input, (out_valid && !out_ready) |-> !in_ready, "input taken while output stalled")

endmodule
`default_nettype wire

// File: verif/luma_band_colour_grade_checker.sv
// checker: watches the pixel channels, predicts each graded word and compares
`default_nettype none
module luma_band_colour_grade_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  lbcg_pkg::pix_in_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  lbcg_pkg::pix_out_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 graded_count
);
  import lbcg_pkg::*;

  localparam longint GREY = 1044480;
  localparam longint TOP = 33554431;
  localparam longint BOTTOM = -33554432;

  logic [63:0] tone_r, red_r, green_r, blue_r;
  logic [15:0] pop_r, sat_r, con_r, bri_r;
  pix_out_t graded_q[$];

  function automatic longint fld(logic [63:0] r, int i);
    logic signed [15:0] v;
    v = r[16*i +: 16];
    return longint'(v);
  endfunction

  function automatic longint round_shr(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint x);
    return x > TOP ? TOP : (x < BOTTOM ? BOTTOM : x);
  endfunction

  function automatic longint luma_q13(longint r, longint g, longint b);
    return round_shr(13933 * r + 46871 * g + 4732 * b, 16);
  endfunction

  function automatic pix_out_t grade_pixel(pix_in_t p);
    longint c[3], x[3], chan[3];
    longint lum, inv, wl, wh, wm, t, wlm, whm, tone, s, yc, n2, d, midw, f, y, v;
    logic [63:0] cr[3];
    pix_out_t o;
    c[0] = p.red_in; c[1] = p.green_in; c[2] = p.blue_in;
    cr[0] = red_r; cr[1] = green_r; cr[2] = blue_r;
    lum = (13933 * c[0] + 46871 * c[1] + 4732 * c[2] + 127) / 255;
    if (lum > 65536) lum = 65536;
    inv = 65536 - lum;
    wl = (inv * inv + 32768) >> 16;
    wh = (lum * lum + 32768) >> 16;
    wm = 65536 - wl - wh;
    if (wm < 0) wm = 0;
    t = (lum - 32768) * 4;
    if (t > 65536) t = 65536;
    if (t < -65536) t = -65536;
    wlm = round_shr(wm * (65536 - t), 17);
    whm = wm - wlm;
    tone = fld(tone_r, 0) * wl + fld(tone_r, 1) * wlm + fld(tone_r, 2) * whm
         + fld(tone_r, 3) * wh;
    for (int i = 0; i < 3; i++) begin
      s = tone + fld(cr[i], 0) * wl + fld(cr[i], 1) * wm + fld(cr[i], 2) * wh;
      x[i] = clip((c[i] << 13) + round_shr(255 * s, 16));
    end
    yc = luma_q13(x[0], x[1], x[2]);
    if (yc < 0) yc = 0;
    if (yc > (255 << 13)) yc = 255 << 13;
    n2 = (yc * 8 + 127) / 255;
    d = 2 * n2 - 65536;
    midw = 65536 - (d < 0 ? -d : d);
    f = round_shr(fld(pop_r, 0) * 13107 * midw, 29);
    for (int i = 0; i < 3; i++) x[i] = clip(x[i] + round_shr(f * (x[i] - GREY), 16));
    y = luma_q13(x[0], x[1], x[2]);
    for (int i = 0; i < 3; i++) x[i] = clip(y + round_shr((x[i] - y) * fld(sat_r, 0), 13));
    for (int i = 0; i < 3; i++) begin
      v = clip(GREY + round_shr((x[i] - GREY) * fld(con_r, 0), 13));
      v = clip(v + fld(bri_r, 0) * 255);
      if (v < 0) v = 0;
      if (v > (255 << 13)) v = 255 << 13;
      chan[i] = (v + 4096) >> 13;
    end
    o.red_out = chan[0][7:0]; o.green_out = chan[1][7:0]; o.blue_out = chan[2][7:0];
    return o;
  endfunction

  assign pending = graded_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      tone_r <= '0; red_r <= '0; green_r <= '0; blue_r <= '0;
      pop_r <= '0; sat_r <= 16'd8192; con_r <= 16'd8192; bri_r <= '0;
      fail_count <= 0;
      graded_count <= 0;
      graded_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_TONE:  tone_r <= cfg_data;
          REG_RED:   red_r <= {16'd0, cfg_data[47:0]};
          REG_GREEN: green_r <= {16'd0, cfg_data[47:0]};
          REG_BLUE:  blue_r <= {16'd0, cfg_data[47:0]};
          REG_POP:   pop_r <= cfg_data[15:0];
          REG_SAT:   sat_r <= cfg_data[15:0];
          REG_CON:   con_r <= cfg_data[15:0];
          REG_BRI:   bri_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        graded_count <= graded_count + 1;
        if (graded_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          pix_out_t e;
          e = graded_q.pop_front();
          if (e !== out_data) begin
            $display("%0t: mismatch, expected %h, actual %h", $time, e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) graded_q.push_back(grade_pixel(in_data));
    end
  end
endmodule
`default_nettype wire

// File: verif/luma_band_colour_grade_top_tb.sv
// testbench top: drives pixels, register writes and idling, gives the verdict
`default_nettype none
module luma_band_colour_grade_top_tb;
  import lbcg_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int fail_count, pending, graded_count;
  int send_idle = 0, recv_idle = 0;
  bit hold_off = 0;

  always #4 clk = ~clk;

  luma_band_colour_grade_top DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  luma_band_colour_grade_checker checker_i (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .graded_count
  );

  // receiver: random stall, plus a long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  task automatic send_word(pix_in_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_gain(int mode);
    case (mode)
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(2048) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_regs(int mode);
    logic [63:0] w;
    w = {rand_gain(mode), rand_gain(mode), rand_gain(mode), rand_gain(mode)};
    write_reg(REG_TONE, w);
    w = {rand_gain(mode), rand_gain(mode), rand_gain(mode), rand_gain(mode)};
    write_reg(REG_RED, w);
    w = {rand_gain(mode), rand_gain(mode), rand_gain(mode), rand_gain(mode)};
    write_reg(REG_GREEN, w);
    w = {rand_gain(mode), rand_gain(mode), rand_gain(mode), rand_gain(mode)};
    write_reg(REG_BLUE, w);
    write_reg(REG_POP, {48'($urandom), rand_gain(mode)});
    write_reg(REG_SAT, {48'($urandom), mode == 2 ? 16'd8192 + rand_gain(2) : rand_gain(mode)});
    write_reg(REG_CON, {48'($urandom), mode == 2 ? 16'd8192 + rand_gain(2) : rand_gain(mode)});
    write_reg(REG_BRI, {48'($urandom), rand_gain(mode)});
    write_reg(4'd8 + 4'($urandom_range(7)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_words(int n);
    for (int i = 0; i < n; i++) send_word(pix_in_t'(24'($urandom)));
  endtask

  initial begin
    #2000000;
    $display("luma_band_colour_grade_top regression: fail");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes and greys at reset setting
    send_word('0);
    send_word('1);
    send_word({8'hff, 8'h00, 8'h00});
    send_word({8'h00, 8'hff, 8'h00});
    send_word({8'h00, 8'h00, 8'hff});
    send_word({8'd128, 8'd127, 8'd128});
    send_word({8'd64, 8'd64, 8'd64});
    send_word({8'd192, 8'd192, 8'd192});
    drain();
    // overflow corners with extreme gains
    load_regs(0);
    send_word('0); send_word('1); send_word({8'd127, 8'd128, 8'd127});
    drain();
    load_regs(1);
    send_word('0); send_word('1); send_word({8'h80, 8'h80, 8'h80});
    drain();
    send_idle = 26; recv_idle = 46;
    for (int ph = 0; ph < 3; ph++) begin
      load_regs(2);
      random_words(60);
      drain();
      load_regs(3);
      random_words(25);
      drain();
    end
    send_idle = 46; recv_idle = 26;
    load_regs(2);
    fork
      random_words(60);
      begin
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
    join
    drain();
    load_regs(3);
    random_words(40);
    drain();
    send_idle = 0; recv_idle = 0;
    load_regs(2);
    random_words(130);
    drain();
    $display("graded %0d words over directed corners and random gain settings", graded_count);
    $display("register extremes, stalls and a long output hold-off were exercised");
    if (fail_count == 0) begin
      $display("luma_band_colour_grade_top regression: pass");
    end else begin
      $display("luma_band_colour_grade_top regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
